### sv/lz4_block_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// LZ4 block decoder assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LZ4_BLOCK_DECODER_CORE_DEFINES_SVH
`define LZ4_BLOCK_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored during reset.
`define LZ4BD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lz4 block decoder: same-cycle check failed");

// Next-cycle implication, sampled on clk and ignored during reset.
`define LZ4BD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lz4 block decoder: next-cycle check failed");

`endif

### sv/lz4bd_pkg.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder package
// Shared constants, status codes and word types of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lz4bd_pkg;

  // Result status codes.
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_END      = 3'd1;
  localparam logic [2:0] ST_BAD_DIST = 3'd2;
  localparam logic [2:0] ST_MISUSE   = 3'd3;
  localparam logic [2:0] ST_OVERSIZE = 3'd4;

  // Saturation limit of the 24-bit counts.
  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  // Output queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  // Per-word operation handed from the parser to the history stage.
  typedef struct packed {
    logic       res;
    logic       copy;
    logic       store;
    logic [7:0] lit;
    logic       end_blk;
    logic [2:0] status;
  } lz4bd_op_t;

  // One result word.
  typedef struct packed {
    logic [7:0] data;
    logic       end_blk;
    logic [2:0] status;
  } lz4bd_res_t;

endpackage

`default_nettype wire

### sv/lz4bd_parser.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder parser
// Sequence parser and block counters; decides each word's result at accept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz4bd_parser #(
  parameter int unsigned WINDOW = 65536,
  parameter int unsigned AW     = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [23:0]      cfg_data,
  input  wire logic             go,
  input  wire logic             action,
  input  wire logic [7:0]       in_byte,
  input  wire logic             last_in,
  output lz4bd_pkg::lz4bd_op_t  op,
  output logic [AW-1:0]         src,
  output logic [AW-1:0]         waddr
);
  import lz4bd_pkg::*;

  typedef enum logic [6:0] {
    PH_TOKEN     = 7'b0000001,
    PH_LIT_EXT   = 7'b0000010,
    PH_LITERAL   = 7'b0000100,
    PH_OFF_LO    = 7'b0001000,
    PH_OFF_HI    = 7'b0010000,
    PH_MATCH_EXT = 7'b0100000,
    PH_MATCH     = 7'b1000000
  } phase_t;

  phase_t        phase, phase_next;
  logic [23:0]   literal_left, literal_left_next;
  logic [23:0]   match_left, match_left_next;
  logic [15:0]   match_distance, match_distance_next;
  logic [AW-1:0] write_pos, write_pos_next;
  logic [23:0]   out_count, out_count_next;
  logic [23:0]   expected_size;

  logic          size_full;
  logic          fail;
  logic [2:0]    fail_st;
  logic          do_store;
  logic          blk_done;
  logic [24:0]   lit_sum, match_sum;
  logic [15:0]   dist_new;
  logic [16:0]   wp_x, dist_x, diff;

  assign size_full = (expected_size != 24'd0) && (out_count >= expected_size);
  assign lit_sum   = {1'b0, literal_left} + 25'(in_byte);
  assign match_sum = {1'b0, match_left} + 25'(in_byte);
  assign dist_new  = {in_byte, match_distance[7:0]};

  // Copy source address: write pointer minus distance, wrapped into the window.
  assign wp_x   = 17'(write_pos);
  assign dist_x = {1'b0, match_distance};
  assign diff   = wp_x - dist_x;
  always_comb begin
    if (wp_x < dist_x) begin
      src = AW'(diff + 17'(WINDOW));
    end else begin
      src = AW'(diff);
    end
  end
  assign waddr = write_pos;

  // Next-state and result decision for the word at the input.
  always_comb begin
    phase_next          = phase;
    literal_left_next   = literal_left;
    match_left_next     = match_left;
    match_distance_next = match_distance;
    op                  = '0;
    fail                = 1'b0;
    fail_st             = ST_MISUSE;
    do_store            = 1'b0;
    blk_done            = 1'b0;

    if (action) begin
      if (phase != PH_MATCH) begin
        fail = 1'b1;
      end else if (size_full) begin
        fail    = 1'b1;
        fail_st = ST_OVERSIZE;
      end else begin
        do_store        = 1'b1;
        op.res          = 1'b1;
        op.copy         = 1'b1;
        match_left_next = match_left - 24'd1;
        if (match_left == 24'd1) begin
          phase_next = PH_TOKEN;
        end
      end
    end else begin
      unique case (phase)
        PH_TOKEN: begin
          literal_left_next = 24'(in_byte[7:4]);
          match_left_next   = 24'(in_byte[3:0]) + 24'd4;
          if (in_byte[7:4] == 4'd0) begin
            if (last_in) begin
              fail    = 1'b1;
              fail_st = ST_END;
            end else begin
              phase_next = PH_OFF_LO;
            end
          end else if (last_in) begin
            fail = 1'b1;
          end else begin
            phase_next = (in_byte[7:4] == 4'hF) ? PH_LIT_EXT : PH_LITERAL;
          end
        end
        PH_LIT_EXT: begin
          if (last_in) begin
            fail = 1'b1;
          end else begin
            literal_left_next = lit_sum[24] ? MAX24 : lit_sum[23:0];
            if (in_byte != 8'hFF) begin
              phase_next = PH_LITERAL;
            end
          end
        end
        PH_LITERAL: begin
          if (last_in && (literal_left != 24'd1)) begin
            fail = 1'b1;
          end else if (size_full) begin
            fail    = 1'b1;
            fail_st = ST_OVERSIZE;
          end else begin
            do_store          = 1'b1;
            op.res            = 1'b1;
            op.store          = 1'b1;
            op.lit            = in_byte;
            literal_left_next = literal_left - 24'd1;
            if (literal_left == 24'd1) begin
              if (last_in) begin
                blk_done   = 1'b1;
                op.end_blk = 1'b1;
              end else begin
                phase_next = PH_OFF_LO;
              end
            end
          end
        end
        PH_OFF_LO: begin
          if (last_in) begin
            fail = 1'b1;
          end else begin
            match_distance_next = 16'(in_byte);
            phase_next          = PH_OFF_HI;
          end
        end
        PH_OFF_HI: begin
          if (last_in) begin
            fail = 1'b1;
          end else if ((dist_new == 16'd0) || (24'(dist_new) > out_count) ||
                       (17'(dist_new) > 17'(WINDOW))) begin
            fail    = 1'b1;
            fail_st = ST_BAD_DIST;
          end else begin
            match_distance_next = dist_new;
            phase_next = (match_left == 24'd19) ? PH_MATCH_EXT : PH_MATCH;
          end
        end
        PH_MATCH_EXT: begin
          if (last_in) begin
            fail = 1'b1;
          end else begin
            match_left_next = match_sum[24] ? MAX24 : match_sum[23:0];
            if (in_byte != 8'hFF) begin
              phase_next = PH_MATCH;
            end
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end

    // A copy stores the byte read back from history.
    if (op.copy) begin
      op.store = 1'b1;
    end

    // Store side effects on the window pointer and the block byte count.
    write_pos_next = write_pos;
    out_count_next = out_count;
    if (do_store) begin
      write_pos_next = (write_pos == AW'(WINDOW - 1)) ? '0 : write_pos + 1'b1;
      out_count_next = (out_count == MAX24) ? out_count : out_count + 24'd1;
    end

    // Errors, empty ends and completed blocks clear the block state.
    if (fail || blk_done) begin
      phase_next          = PH_TOKEN;
      literal_left_next   = '0;
      match_left_next     = '0;
      match_distance_next = '0;
      out_count_next      = '0;
    end
    if (fail) begin
      op.res     = 1'b1;
      op.end_blk = 1'b1;
      op.status  = fail_st;
    end
  end

  // Block state registers, updated on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TOKEN;
      literal_left   <= '0;
      match_left     <= '0;
      match_distance <= '0;
      write_pos      <= '0;
      out_count      <= '0;
    end else if (go) begin
      phase          <= phase_next;
      literal_left   <= literal_left_next;
      match_left     <= match_left_next;
      match_distance <= match_distance_next;
      write_pos      <= write_pos_next;
      out_count      <= out_count_next;
    end
  end

  // Size limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size <= '0;
    end else if (cfg_we) begin
      expected_size <= cfg_data;
    end
  end

endmodule

`default_nettype wire

### sv/lz4bd_history.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder history stage
// Window memory with registered read, write-back and last-write forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz4bd_history #(
  parameter int unsigned WINDOW = 65536,
  parameter int unsigned AW     = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire lz4bd_pkg::lz4bd_op_t op,
  input  wire logic [AW-1:0]        src,
  input  wire logic [AW-1:0]        waddr,
  output logic                      res_valid,
  output lz4bd_pkg::lz4bd_res_t     res
);
  import lz4bd_pkg::*;

  logic [7:0]    mem [WINDOW];
  logic [7:0]    rd_data;

  // Second-stage registers.
  logic          s1_copy;
  logic          s1_store;
  logic [7:0]    s1_lit;
  logic          s1_end;
  logic [2:0]    s1_status;
  logic [AW-1:0] s1_src;
  logic [AW-1:0] s1_waddr;

  // The write made at the edge of the current read, which the read missed.
  logic          lw_valid;
  logic [AW-1:0] lw_addr;
  logic [7:0]    lw_data;

  logic [7:0]    s1_data;
  logic          s1_wr;

  // Memory read for a copy word, registered.
  always_ff @(posedge clk) begin
    if (go && op.copy) begin
      rd_data <= mem[src];
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= go && op.res;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (go) begin
      s1_copy   <= op.copy;
      s1_store  <= op.store;
      s1_lit    <= op.lit;
      s1_end    <= op.end_blk;
      s1_status <= op.status;
      s1_src    <= src;
      s1_waddr  <= waddr;
    end
  end

  // Copy data comes from memory unless the previous word just wrote it.
  always_comb begin
    if (!s1_copy) begin
      s1_data = s1_lit;
    end else if (lw_valid && (lw_addr == s1_src)) begin
      s1_data = lw_data;
    end else begin
      s1_data = rd_data;
    end
  end
  assign s1_wr = res_valid && s1_store;

  // Write-back of every output data byte.
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_waddr] <= s1_data;
    end
  end

  // Forwarding register for the write that the next read cannot see.
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else begin
      lw_valid <= s1_wr;
    end
  end
  always_ff @(posedge clk) begin
    lw_addr <= s1_waddr;
    lw_data <= s1_data;
  end

  assign res.data    = s1_data;
  assign res.end_blk = s1_end;
  assign res.status  = s1_status;

endmodule

`default_nettype wire

### sv/lz4bd_out_fifo.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder output queue
// Small result queue that decouples the receiver from the decode pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz4bd_out_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire lz4bd_pkg::lz4bd_res_t push_word,
  input  wire logic                  pending,
  input  wire logic                  pop,
  output logic                       head_valid,
  output lz4bd_pkg::lz4bd_res_t      head_word,
  output logic                       room,
  output logic                       full
);
  import lz4bd_pkg::*;

  lz4bd_res_t         entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_valid = (count != '0);
  assign head_word  = entries[rd_ptr];
  assign full       = (count == FIFO_CW'(FIFO_DEPTH));

  // A new word may enter if a slot stays free for it after the one in flight.
  assign room = (count + FIFO_CW'(pending)) < FIFO_CW'(FIFO_DEPTH);

endmodule

`default_nettype wire

### sv/lz4_block_decoder_core.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder core
// Decodes LZ4 block sequences into bytes over a window history memory.
// ----------------------------------------------------------------------------
// Usage: each input word is either a compressed byte (action 0) or a request
// to emit the next byte of a pending match (action 1); last_in marks the
// final compressed byte of a block. Words move on a valid/ready handshake.
// Literal bytes and copied match bytes come out as data words; parse bytes
// give no output word. Errors and an empty block end give one word with a
// nonzero status and end_of_block set, and restart parsing at a token.
// Throughput is one input word per cycle while in_ready is high, matches
// included: the window memory is read once per copy word, and a one-deep
// forwarding register covers a copy that reads the byte written by the word
// just before it. The parse result and memory read are registered, then the
// word is written back into the four-entry output queue.
// If the receiver stalls, the queue fills and in_ready drops; no word is
// lost. Reset clears the parser, the counts, the queue and expected_size;
// the window memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lz4_block_decoder_core_defines.svh"

module lz4_block_decoder_core #(
  parameter int unsigned WINDOW = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [7:0]  in_byte,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             end_of_block,
  output logic [2:0]       status
);
  import lz4bd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW);

  lz4bd_op_t     op;
  logic [AW-1:0] src;
  logic [AW-1:0] waddr;
  logic          acc;
  logic          res_valid;
  lz4bd_res_t    res;
  lz4bd_res_t    head;
  logic          room;
  logic          full;

  assign in_ready = room;
  assign acc      = in_valid && in_ready;

  // Sequence parser and block counters.
  lz4bd_parser #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .go       (acc),
    .action   (action),
    .in_byte  (in_byte),
    .last_in  (last_in),
    .op       (op),
    .src      (src),
    .waddr    (waddr)
  );

  // Window memory and result stage.
  lz4bd_history #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .go        (acc),
    .op        (op),
    .src       (src),
    .waddr     (waddr),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output queue.
  lz4bd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_word  (res),
    .pending    (res_valid),
    .pop        (out_valid && out_ready),
    .head_valid (out_valid),
    .head_word  (head),
    .room       (room),
    .full       (full)
  );

  assign out_byte     = head.data;
  assign end_of_block = head.end_blk;
  assign status       = head.status;

  // Checks on the decoder's own logic.
  `LZ4BD_ASSERT_IMPLY(a_no_overflow, res_valid, !full)
  `LZ4BD_ASSERT_NEXT(a_result_follows, acc && op.res, res_valid)
  `LZ4BD_ASSERT_IMPLY(a_error_ends, out_valid && (status != ST_DATA), end_of_block)
  `LZ4BD_ASSERT_IMPLY(a_error_no_data, out_valid && (status != ST_DATA), out_byte == 8'h00)

endmodule

`default_nettype wire
